>>> rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
package lrupr_pkg;

   localparam int FRAMES    = 8;
   localparam int PAGE_BITS = 16;
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W    = IDX_W;
   localparam int CSR_W     = 4;
   localparam int FAULT_W   = 16;

   localparam logic [RANK_W-1:0]  RANK_MAX    = RANK_W'(FRAMES - 1);
   localparam logic [FAULT_W-1:0] FAULT_MAX   = '1;
   localparam logic [CSR_W-1:0]   COUNT_RESET = CSR_W'(FRAMES);

   // running search result handed from cell to cell
   typedef struct packed {
      logic                 hit;
      logic [IDX_W-1:0]     hit_slot;
      logic [RANK_W-1:0]    hit_rank;
      logic                 empty;
      logic [IDX_W-1:0]     empty_slot;
      logic                 vic_valid;
      logic [IDX_W-1:0]     vic_slot;
      logic [RANK_W-1:0]    vic_rank;
      logic [PAGE_BITS-1:0] vic_page;
   } carry_type;

   localparam carry_type CARRY_INIT = '0;

   // decision broadcast to every cell
   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     slot;
      logic                 fill;
      logic [PAGE_BITS-1:0] page;
      logic [RANK_W-1:0]    limit;
      logic                 age_all;
      logic                 clear;
   } update_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

>>> rtl/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// a new reference is taken only in the idle state, once the previous one has been updated
// the search walks one cell per cycle over the frames in use; busy stays high through the update
// results are shown for exactly one cycle; the receiver cannot stall them
// reset (synchronous, active high): all frames invalid, ranks and fault count zero,
// frame count 8; no clearing pass, the block takes references on the next cycle
module lru_page_replacement_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_page,
   input  logic        req_end_of_string,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [2:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_page,
   output logic [15:0] rsp_fault_total
);

   // carry chain: cell i registers the search result over frames 0..i
   lrupr_pkg::carry_type             carry [lrupr_pkg::FRAMES];
   lrupr_pkg::carry_type             tail;
   lrupr_pkg::update_type            upd;
   logic [lrupr_pkg::CSR_W-1:0]      used_n;
   logic [lrupr_pkg::FRAMES-1:0]     in_use;

   // the last frame in use holds the finished search
   assign tail = carry[lrupr_pkg::IDX_W'(used_n - 1'b1)];

   genvar gi;
   generate
      for (gi = 0; gi < lrupr_pkg::FRAMES; gi++) begin : g_cell
         // frames beyond the count pass the carry; only a clear changes their contents
         assign in_use[gi] = (lrupr_pkg::CSR_W'(gi) < used_n);

         if (gi == 0) begin : g_head
            lrupr_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .cell_idx  (lrupr_pkg::IDX_W'(gi)),
               .in_use    (in_use[gi]),
               .carry_in  (lrupr_pkg::CARRY_INIT),
               .carry_out (carry[gi]),
               .upd       (upd)
            );
         end else begin : g_body
            lrupr_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .cell_idx  (lrupr_pkg::IDX_W'(gi)),
               .in_use    (in_use[gi]),
               .carry_in  (carry[gi-1]),
               .carry_out (carry[gi]),
               .upd       (upd)
            );
         end
      end
   endgenerate

   // sequencer: holds the beat, counts the scan, broadcasts the decision
   lrupr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page          (req_page),
      .req_end_of_string (req_end_of_string),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .tail              (tail),
      .used_n            (used_n),
      .upd               (upd),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

>>> rtl/lrupr_cell.sv
`timescale 1ns / 1ps
module lrupr_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lrupr_pkg::IDX_W-1:0]        cell_idx,
   input  logic                               in_use,
   input  lrupr_pkg::carry_type               carry_in,
   output lrupr_pkg::carry_type               carry_out,
   input  lrupr_pkg::update_type              upd
);

   logic                                 valid_ff, valid_in;
   logic [lrupr_pkg::RANK_W-1:0]         rank_ff, rank_in;
   logic [lrupr_pkg::PAGE_BITS-1:0]      page_ff, page_in;
   lrupr_pkg::carry_type                 carry_ff, carry_in_next;

   // fold this frame into the running search
   always_comb begin
      carry_in_next = carry_in;
      if (in_use) begin
         if (!carry_in.hit && valid_ff && (page_ff == upd.page)) begin
            carry_in_next.hit      = 1'b1;
            carry_in_next.hit_slot = cell_idx;
            carry_in_next.hit_rank = rank_ff;
         end
         if (!carry_in.empty && !valid_ff) begin
            carry_in_next.empty      = 1'b1;
            carry_in_next.empty_slot = cell_idx;
         end
         if (!carry_in.vic_valid || (rank_ff > carry_in.vic_rank)) begin
            carry_in_next.vic_valid = 1'b1;
            carry_in_next.vic_slot  = cell_idx;
            carry_in_next.vic_rank  = rank_ff;
            carry_in_next.vic_page  = page_ff;
         end
      end
   end

   // apply the broadcast decision
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      page_in  = page_ff;
      if (upd.en && in_use) begin
         if (cell_idx == upd.slot) begin
            rank_in = '0;
            if (upd.fill) begin
               valid_in = 1'b1;
               page_in  = upd.page;
            end
         end else if (valid_ff && (upd.age_all || (rank_ff < upd.limit))
                      && (rank_ff != lrupr_pkg::RANK_MAX)) begin
            rank_in = rank_ff + 1'b1;
         end
      end
      if (upd.en && upd.clear) begin
         valid_in = 1'b0;
         rank_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      page_ff  <= page_in;
      carry_ff <= carry_in_next;
   end

   assign carry_out = carry_ff;

endmodule

>>> rtl/lrupr_ctrl.sv
`timescale 1ns / 1ps
module lrupr_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [lrupr_pkg::PAGE_BITS-1:0]      req_page,
   input  logic                                 req_end_of_string,
   input  logic                                 csr_we,
   input  logic [lrupr_pkg::CSR_W-1:0]          csr_wdata,
   input  lrupr_pkg::carry_type                 tail,
   output logic [lrupr_pkg::CSR_W-1:0]          used_n,
   output lrupr_pkg::update_type                upd,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [2:0]                           rsp_frame_index,
   output logic                                 rsp_evicted_valid,
   output logic [15:0]                          rsp_evicted_page,
   output logic [15:0]                          rsp_fault_total
);

   lrupr_pkg::state_type                state_ff, state_in;
   logic [lrupr_pkg::IDX_W-1:0]         cnt_ff, cnt_in;
   logic [lrupr_pkg::PAGE_BITS-1:0]     page_ff, page_in;
   logic                                last_ff, last_in;
   logic [lrupr_pkg::CSR_W-1:0]         count_ff;
   logic [lrupr_pkg::FAULT_W-1:0]       fault_ff, fault_in, fault_next;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [lrupr_pkg::IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                                rsp_ev_ff, rsp_ev_in;
   logic [lrupr_pkg::PAGE_BITS-1:0]     rsp_evp_ff, rsp_evp_in;
   logic [lrupr_pkg::FAULT_W-1:0]       rsp_flt_ff, rsp_flt_in;
   logic [lrupr_pkg::IDX_W-1:0]         last_idx;
   logic                                evict;

   // frames in use, clamped to 1..FRAMES
   always_comb begin
      if (count_ff == '0) begin
         used_n = lrupr_pkg::CSR_W'(1);
      end else if (count_ff > lrupr_pkg::CSR_W'(lrupr_pkg::FRAMES)) begin
         used_n = lrupr_pkg::CSR_W'(lrupr_pkg::FRAMES);
      end else begin
         used_n = count_ff;
      end
   end

   assign last_idx = lrupr_pkg::IDX_W'(used_n - 1'b1);

   // decision from the search result at the tail of the chain
   always_comb begin
      upd.en    = 1'b0;
      upd.page  = page_ff;
      upd.clear = last_ff;
      evict     = 1'b0;
      if (tail.hit) begin
         upd.slot    = tail.hit_slot;
         upd.fill    = 1'b0;
         upd.limit   = tail.hit_rank;
         upd.age_all = 1'b0;
      end else begin
         upd.fill    = 1'b1;
         upd.limit   = '0;
         upd.age_all = 1'b1;
         if (tail.empty) begin
            upd.slot = tail.empty_slot;
         end else begin
            upd.slot = tail.vic_slot;
            evict    = 1'b1;
         end
      end
      if (!tail.hit && (fault_ff != lrupr_pkg::FAULT_MAX)) begin
         fault_next = fault_ff + 1'b1;
      end else begin
         fault_next = fault_ff;
      end

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      page_in      = page_ff;
      last_in      = last_ff;
      fault_in     = fault_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evp_in   = rsp_evp_ff;
      rsp_flt_in   = rsp_flt_ff;

      case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            if (start) begin
               page_in  = req_page;
               last_in  = req_end_of_string;
               cnt_in   = '0;
               state_in = lrupr_pkg::ST_SCAN;
            end
         end
         lrupr_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == last_idx) begin
               state_in = lrupr_pkg::ST_UPDATE;
            end
         end
         lrupr_pkg::ST_UPDATE: begin
            upd.en       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = tail.hit;
            rsp_idx_in   = upd.slot;
            rsp_ev_in    = evict;
            rsp_evp_in   = evict ? tail.vic_page : '0;
            // fault count after this beat, taken before an end-of-string clear
            rsp_flt_in   = fault_next;
            fault_in     = last_ff ? '0 : fault_next;
            state_in     = lrupr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrupr_pkg::ST_IDLE;
         count_ff     <= lrupr_pkg::COUNT_RESET;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
      cnt_ff     <= cnt_in;
      page_ff    <= page_in;
      last_ff    <= last_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_evp_ff <= rsp_evp_in;
      rsp_flt_ff <= rsp_flt_in;
   end

   assign busy              = (state_ff != lrupr_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = 3'(rsp_idx_ff);
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = 16'(rsp_evp_ff);
   assign rsp_fault_total   = 16'(rsp_flt_ff);

endmodule
